FILE: hw/rtl/tfcn_pkg.sv
`timescale 1ns / 1ps
// tfcn_pkg: shared constants, state encoding and divider result type for
// the thermal frame contrast normalizer; no dependencies
package tfcn_pkg;

   localparam int PIXEL_W            = 16;
   localparam int HISTORY_DEPTH      = 16;
   localparam int HIST_AW            = $clog2(HISTORY_DEPTH);
   localparam int WIN_W              = $clog2(HISTORY_DEPTH + 1);
   localparam int FRAME_COUNT_W      = 5;
   localparam int GAIN_FRACTION_BITS = 16;
   localparam int GAIN_W             = PIXEL_W + GAIN_FRACTION_BITS;
   localparam int PROD_W             = PIXEL_W + GAIN_W;
   localparam int DIV_STEP_W         = $clog2(GAIN_W);
   localparam int CSR_INDEX_W        = 1;
   localparam int CSR_DATA_W         = FRAME_COUNT_W;

   localparam logic [PIXEL_W-1:0] FULL_SCALE = {PIXEL_W{1'b1}};
   localparam logic [GAIN_W-1:0]  DIVIDEND   = GAIN_W'(FULL_SCALE) << GAIN_FRACTION_BITS;

   localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = FRAME_COUNT_W'(8);

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE      = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_COUNT = CSR_INDEX_W'(1);

   localparam logic OP_MEASURE = 1'b0;
   localparam logic OP_APPLY   = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_STORE,
      ST_MED_LOAD,
      ST_MED_CAND,
      ST_MED_SCAN,
      ST_MED_CHECK,
      ST_FINISH,
      ST_DIV_WAIT,
      ST_APPLY_SUB,
      ST_APPLY_MUL
   } state_type;

   typedef struct packed {
      logic              done;
      logic [GAIN_W-1:0] quotient;
   } div_result_type;

endpackage

FILE: hw/rtl/tfcn_gain_div.sv
`timescale 1ns / 1ps
// tfcn_gain_div: restoring divider, one quotient bit per cycle, that forms
// the stretch gain full_scale * 2^frac / span; uses tfcn_pkg
module tfcn_gain_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tfcn_pkg::PIXEL_W-1:0]  divisor,
   output tfcn_pkg::div_result_type      result
);
   import tfcn_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [PIXEL_W-1:0]    rem_ff, rem_in;
   logic [PIXEL_W-1:0]    dsr_ff, dsr_in;
   logic [GAIN_W-1:0]     dvd_ff, dvd_in;
   logic [GAIN_W-1:0]     quo_ff, quo_in;
   logic [PIXEL_W:0]      rem_sh;
   logic [PIXEL_W:0]      rem_diff;
   logic                  fits;

   always_comb begin
      rem_sh   = {rem_ff, dvd_ff[GAIN_W-1]};
      rem_diff = rem_sh - {1'b0, dsr_ff};
      fits     = (rem_sh >= {1'b0, dsr_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;

      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dsr_in  = divisor;
         dvd_in  = DIVIDEND;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? rem_diff[PIXEL_W-1:0] : rem_sh[PIXEL_W-1:0];
         dvd_in  = {dvd_ff[GAIN_W-2:0], 1'b0};
         quo_in  = {quo_ff[GAIN_W-2:0], fits};
         step_in = step_ff + DIV_STEP_W'(1);
         if (step_ff == DIV_STEP_W'(GAIN_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
   end

   assign result.done     = done_ff;
   assign result.quotient = quo_ff;

endmodule

FILE: hw/rtl/thermal_frame_contrast_normalizer.sv
`timescale 1ns / 1ps
// A measure beat is taken in the idle state; an apply beat is latched,
// then subtracted, then multiplied (one 16x32 multiply with saturation into
// the output register), the multiply waiting while that register is full.
// The measure beat that ends a frame, with stretch enabled, starts the frame
// statistics update and the block takes no beat until it is done: a fill of
// all 16 history entries on the first frame after reset, the ring write, then
// a median search that runs one shared comparator per history over the
// history memory per candidate, up to n candidates (n = window length),
// then the finish step and, unless the window is flat, a 32-bit bit-serial
// divide. Results wait in an output register, so measure beats keep flowing
// while a result is held. There is no clearing pass after reset.
module thermal_frame_contrast_normalizer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [tfcn_pkg::PIXEL_W-1:0]      req_tdata,   // pixel_in
   input  logic                              req_tuser,   // opcode
   input  logic                              req_tlast,   // frame_end
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tfcn_pkg::PIXEL_W-1:0]      rsp_tdata,   // pixel_out
   output logic                              rsp_tlast,   // frame_end_out
   input  logic                              csr_we,
   input  logic [tfcn_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tfcn_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tfcn_pkg::*;

   state_type              state_ff, state_in;
   logic                   enable_ff, enable_in;
   logic [FRAME_COUNT_W-1:0] fc_ff, fc_in;
   logic [PIXEL_W-1:0]     run_min_ff, run_min_in;
   logic [PIXEL_W-1:0]     run_max_ff, run_max_in;
   logic [HIST_AW-1:0]     pos_ff, pos_in;
   logic                   hist_empty_ff, hist_empty_in;
   logic [PIXEL_W-1:0]     low_ff, low_in;
   logic [GAIN_W-1:0]      gain_ff, gain_in;
   logic                   flat_ff, flat_in;
   logic [HIST_AW-1:0]     fill_idx_ff, fill_idx_in;
   logic [HIST_AW-1:0]     cand_ff, cand_in;
   logic [HIST_AW-1:0]     j_ff, j_in;
   logic                   found_min_ff, found_min_in;
   logic                   found_max_ff, found_max_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [WIN_W-1:0]       less_min_ff, less_min_in;
   logic [WIN_W-1:0]       eq_min_ff, eq_min_in;
   logic [WIN_W-1:0]       less_max_ff, less_max_in;
   logic [WIN_W-1:0]       eq_max_ff, eq_max_in;
   logic [PIXEL_W-1:0]     cmin_ff, cmin_in;
   logic [PIXEL_W-1:0]     cmax_ff, cmax_in;
   logic [PIXEL_W-1:0]     med_lo_ff, med_lo_in;
   logic [PIXEL_W-1:0]     med_hi_ff, med_hi_in;
   logic [PIXEL_W-1:0]     px_ff, px_in;
   logic                   fe_ff, fe_in;
   logic [PIXEL_W-1:0]     diff_ff, diff_in;
   logic                   below_ff, below_in;
   logic [PIXEL_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [PIXEL_W-1:0]     min_mem [HISTORY_DEPTH];
   logic [PIXEL_W-1:0]     max_mem [HISTORY_DEPTH];
   logic [PIXEL_W-1:0]     rd_min_ff;
   logic [PIXEL_W-1:0]     rd_max_ff;
   logic                   mem_we;
   logic [HIST_AW-1:0]     mem_waddr;
   logic [HIST_AW-1:0]     rd_addr;

   logic [WIN_W-1:0]       win_len;
   logic [WIN_W-1:0]       win_last;
   logic [WIN_W-1:0]       rank;
   logic [WIN_W-1:0]       next_pos;
   logic                   hit_min;
   logic                   hit_max;
   logic [PROD_W-1:0]      prod;
   logic [PIXEL_W-1:0]     stretched;
   logic                   div_start;
   div_result_type         div_res;

   tfcn_gain_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (med_hi_ff - med_lo_ff),
      .result  (div_res)
   );

   // window length clamped to 1..depth
   always_comb begin
      if (fc_ff == '0) begin
         win_len = WIN_W'(1);
      end else if (int'(fc_ff) > HISTORY_DEPTH) begin
         win_len = WIN_W'(HISTORY_DEPTH);
      end else begin
         win_len = WIN_W'(fc_ff);
      end
      win_last = win_len - WIN_W'(1);
      rank     = win_len >> 1;
      next_pos = WIN_W'(pos_ff) + WIN_W'(1);
      if (next_pos >= win_len) begin
         next_pos = '0;
      end
   end

   // candidate is the median when rank falls inside its run of equal values
   assign hit_min = !found_min_ff && (less_min_ff <= rank)
                    && (rank < less_min_ff + eq_min_ff);
   assign hit_max = !found_max_ff && (less_max_ff <= rank)
                    && (rank < less_max_ff + eq_max_ff);

   assign prod = PROD_W'(diff_ff) * PROD_W'(gain_ff);

   always_comb begin
      if (prod[PROD_W-1:GAIN_FRACTION_BITS+PIXEL_W] != '0) begin
         stretched = FULL_SCALE;
      end else begin
         stretched = prod[GAIN_FRACTION_BITS+PIXEL_W-1:GAIN_FRACTION_BITS];
      end
   end

   always_comb begin
      state_in      = state_ff;
      enable_in     = enable_ff;
      fc_in         = fc_ff;
      run_min_in    = run_min_ff;
      run_max_in    = run_max_ff;
      pos_in        = pos_ff;
      hist_empty_in = hist_empty_ff;
      low_in        = low_ff;
      gain_in       = gain_ff;
      flat_in       = flat_ff;
      fill_idx_in   = fill_idx_ff;
      cand_in       = cand_ff;
      j_in          = j_ff;
      found_min_in  = found_min_ff;
      found_max_in  = found_max_ff;
      less_min_in   = less_min_ff;
      eq_min_in     = eq_min_ff;
      less_max_in   = less_max_ff;
      eq_max_in     = eq_max_ff;
      cmin_in       = cmin_ff;
      cmax_in       = cmax_ff;
      med_lo_in     = med_lo_ff;
      med_hi_in     = med_hi_ff;
      px_in         = px_ff;
      fe_in         = fe_ff;
      diff_in       = diff_ff;
      below_in      = below_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      mem_we        = 1'b0;
      mem_waddr     = pos_ff;
      rd_addr       = '0;
      div_start     = 1'b0;
      req_tready    = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_ENABLE: begin
               enable_in = csr_wdata[0];
            end
            CSR_FRAME_COUNT: begin
               fc_in  = csr_wdata;
               pos_in = '0;
            end
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == OP_APPLY) begin
                  px_in    = req_tdata;
                  fe_in    = req_tlast;
                  state_in = ST_APPLY_SUB;
               end else if (enable_ff) begin
                  if (req_tdata < run_min_ff) begin
                     run_min_in = req_tdata;
                  end
                  if (req_tdata > run_max_ff) begin
                     run_max_in = req_tdata;
                  end
                  if (req_tlast) begin
                     fill_idx_in = '0;
                     state_in    = hist_empty_ff ? ST_FILL : ST_STORE;
                  end
               end
            end
         end
         ST_FILL: begin
            mem_we      = 1'b1;
            mem_waddr   = fill_idx_ff;
            fill_idx_in = fill_idx_ff + HIST_AW'(1);
            if (fill_idx_ff == HIST_AW'(HISTORY_DEPTH - 1)) begin
               hist_empty_in = 1'b0;
               state_in      = ST_STORE;
            end
         end
         ST_STORE: begin
            pos_in       = HIST_AW'(next_pos);
            mem_we       = 1'b1;
            mem_waddr    = HIST_AW'(next_pos);
            run_min_in   = FULL_SCALE;
            run_max_in   = '0;
            cand_in      = '0;
            found_min_in = 1'b0;
            found_max_in = 1'b0;
            state_in     = ST_MED_LOAD;
         end
         ST_MED_LOAD: begin
            rd_addr  = cand_ff;
            state_in = ST_MED_CAND;
         end
         ST_MED_CAND: begin
            cmin_in     = rd_min_ff;
            cmax_in     = rd_max_ff;
            less_min_in = '0;
            eq_min_in   = '0;
            less_max_in = '0;
            eq_max_in   = '0;
            j_in        = '0;
            rd_addr     = '0;
            state_in    = ST_MED_SCAN;
         end
         ST_MED_SCAN: begin
            less_min_in = less_min_ff + WIN_W'(rd_min_ff < cmin_ff);
            eq_min_in   = eq_min_ff + WIN_W'(rd_min_ff == cmin_ff);
            less_max_in = less_max_ff + WIN_W'(rd_max_ff < cmax_ff);
            eq_max_in   = eq_max_ff + WIN_W'(rd_max_ff == cmax_ff);
            j_in        = j_ff + HIST_AW'(1);
            rd_addr     = j_ff + HIST_AW'(1);
            if (WIN_W'(j_ff) == win_last) begin
               state_in = ST_MED_CHECK;
            end
         end
         ST_MED_CHECK: begin
            if (hit_min) begin
               found_min_in = 1'b1;
               med_lo_in    = cmin_ff;
            end
            if (hit_max) begin
               found_max_in = 1'b1;
               med_hi_in    = cmax_ff;
            end
            if ((found_min_ff || hit_min) && (found_max_ff || hit_max)) begin
               state_in = ST_FINISH;
            end else begin
               cand_in  = cand_ff + HIST_AW'(1);
               state_in = ST_MED_LOAD;
            end
         end
         ST_FINISH: begin
            low_in = med_lo_ff;
            if (med_hi_ff <= med_lo_ff) begin
               flat_in  = 1'b1;
               gain_in  = '0;
               state_in = ST_IDLE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_res.done) begin
               gain_in  = div_res.quotient;
               flat_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         ST_APPLY_SUB: begin
            below_in = (px_ff < low_ff);
            diff_in  = px_ff - low_ff;
            state_in = ST_APPLY_MUL;
         end
         ST_APPLY_MUL: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = fe_ff;
               if (enable_ff && !flat_ff) begin
                  rsp_data_in = below_ff ? '0 : stretched;
               end else begin
                  rsp_data_in = px_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         enable_ff     <= 1'b1;
         fc_ff         <= FRAME_COUNT_RESET;
         run_min_ff    <= FULL_SCALE;
         run_max_ff    <= '0;
         pos_ff        <= '0;
         hist_empty_ff <= 1'b1;
         low_ff        <= '0;
         gain_ff       <= '0;
         flat_ff       <= 1'b1;
         fill_idx_ff   <= '0;
         cand_ff       <= '0;
         j_ff          <= '0;
         found_min_ff  <= 1'b0;
         found_max_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         enable_ff     <= enable_in;
         fc_ff         <= fc_in;
         run_min_ff    <= run_min_in;
         run_max_ff    <= run_max_in;
         pos_ff        <= pos_in;
         hist_empty_ff <= hist_empty_in;
         low_ff        <= low_in;
         gain_ff       <= gain_in;
         flat_ff       <= flat_in;
         fill_idx_ff   <= fill_idx_in;
         cand_ff       <= cand_in;
         j_ff          <= j_in;
         found_min_ff  <= found_min_in;
         found_max_ff  <= found_max_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      less_min_ff <= less_min_in;
      eq_min_ff   <= eq_min_in;
      less_max_ff <= less_max_in;
      eq_max_ff   <= eq_max_in;
      cmin_ff     <= cmin_in;
      cmax_ff     <= cmax_in;
      med_lo_ff   <= med_lo_in;
      med_hi_ff   <= med_hi_in;
      px_ff       <= px_in;
      fe_ff       <= fe_in;
      diff_ff     <= diff_in;
      below_ff    <= below_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // history memories, one write and one registered read port each
   always_ff @(posedge clock) begin
      if (mem_we) begin
         min_mem[mem_waddr] <= run_min_ff;
         max_mem[mem_waddr] <= run_max_ff;
      end
      rd_min_ff <= min_mem[rd_addr];
      rd_max_ff <= max_mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> state_ff == ST_DIV_WAIT)
      else $error("divider finished outside the gain wait");

   a_median_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MED_CHECK && WIN_W'(cand_ff) == win_last)
      |-> ((found_min_ff || hit_min) && (found_max_ff || hit_max)))
      else $error("median search ran past the window");

   a_ring_in_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MED_LOAD |-> WIN_W'(pos_ff) < win_len)
      else $error("ring position outside the window");

endmodule

FILE: verif/thermal_frame_contrast_normalizer_test.sv
`timescale 1ns / 1ps
// thermal_frame_contrast_normalizer_test: self-checking bench that replays frames as
// measure and apply passes, predicts every stretched pixel and compares it beat by beat
// depends on tfcn_pkg and thermal_frame_contrast_normalizer
module thermal_frame_contrast_normalizer_test;
   import tfcn_pkg::*;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               last;
   } out_pixel_type;

   class contrast_scoreboard;
      out_pixel_type      expected_pixels[$];
      int                 errors;
      logic               norm_en;
      logic [CSR_DATA_W-1:0] frame_cnt;
      logic [PIXEL_W-1:0] run_min;
      logic [PIXEL_W-1:0] run_max;
      logic [PIXEL_W-1:0] min_hist[HISTORY_DEPTH];
      logic [PIXEL_W-1:0] max_hist[HISTORY_DEPTH];
      int                 ring_pos;
      bit                 hist_empty;
      logic [PIXEL_W-1:0] low_med;
      logic [GAIN_W-1:0]  gain;
      bit                 flat;

      function new();
         errors     = 0;
         norm_en    = 1'b1;
         frame_cnt  = FRAME_COUNT_RESET;
         run_min    = FULL_SCALE;
         run_max    = '0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            min_hist[i] = '0;
            max_hist[i] = '0;
         end
         ring_pos   = 0;
         hist_empty = 1'b1;
         low_med    = '0;
         gain       = '0;
         flat       = 1'b1;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_ENABLE) begin
            norm_en = val[0];
         end else if (idx == CSR_FRAME_COUNT) begin
            frame_cnt = val;
            ring_pos  = 0;
         end
      endfunction

      function int window_len();
         if (frame_cnt == 0) return 1;
         if (frame_cnt > HISTORY_DEPTH) return HISTORY_DEPTH;
         return int'(frame_cnt);
      endfunction

      function logic [PIXEL_W-1:0] median_of(bit use_max, int n);
         logic [PIXEL_W-1:0] vals[HISTORY_DEPTH];
         logic [PIXEL_W-1:0] v;
         int j;
         for (int i = 0; i < n; i++) begin
            v = use_max ? max_hist[i] : min_hist[i];
            j = i;
            while (j > 0 && vals[j-1] > v) begin
               vals[j] = vals[j-1];
               j--;
            end
            vals[j] = v;
         end
         return vals[n/2];
      endfunction

      function void store_frame();
         int n;
         logic [PIXEL_W-1:0] lo;
         logic [PIXEL_W-1:0] hi;
         logic [63:0] quot;
         n = window_len();
         if (hist_empty) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
               min_hist[i] = run_min;
               max_hist[i] = run_max;
            end
            hist_empty = 1'b0;
         end
         ring_pos++;
         if (ring_pos >= n) ring_pos = 0;
         min_hist[ring_pos] = run_min;
         max_hist[ring_pos] = run_max;
         hi = median_of(1'b1, n);
         lo = median_of(1'b0, n);
         low_med = lo;
         if (hi <= lo) begin
            flat = 1'b1;
            gain = '0;
         end else begin
            quot = (64'(FULL_SCALE) << GAIN_FRACTION_BITS) / 64'(hi - lo);
            if (quot > 64'hFFFF_FFFF) quot = 64'hFFFF_FFFF;
            flat = 1'b0;
            gain = quot[GAIN_W-1:0];
         end
         run_min = FULL_SCALE;
         run_max = '0;
      endfunction

      function void note_input(logic op, logic [PIXEL_W-1:0] px, logic fe);
         out_pixel_type beat;
         logic [63:0] prod;
         if (op == OP_MEASURE) begin
            if (!norm_en) return;
            if (px < run_min) run_min = px;
            if (px > run_max) run_max = px;
            if (fe) store_frame();
            return;
         end
         beat.last = fe;
         if (norm_en && !flat) begin
            if (px < low_med) begin
               beat.pixel = '0;
            end else begin
               prod = (64'(px - low_med) * 64'(gain)) >> GAIN_FRACTION_BITS;
               beat.pixel = (prod > 64'(FULL_SCALE)) ? FULL_SCALE : prod[PIXEL_W-1:0];
            end
         end else begin
            beat.pixel = px;
         end
         expected_pixels.push_back(beat);
      endfunction

      function void check_result(logic [PIXEL_W-1:0] px, logic fe);
         out_pixel_type beat;
         if (expected_pixels.size() == 0) begin
            $display("%0t: output beat with none expected, actual pixel_out %h frame_end_out %b",
                     $time, px, fe);
            errors++;
            return;
         end
         beat = expected_pixels.pop_front();
         if (beat.pixel !== px) begin
            $display("%0t: pixel_out expected %h actual %h", $time, beat.pixel, px);
            errors++;
         end
         if (beat.last !== fe) begin
            $display("%0t: frame_end_out expected %b actual %b", $time, beat.last, fe);
            errors++;
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   localparam int SETTLE_CYCLES = 400;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SEGMENT_BEATS = 170;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [PIXEL_W-1:0]     req_tdata;   // pixel_in
   logic                   req_tuser;   // opcode
   logic                   req_tlast;   // frame_end
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [PIXEL_W-1:0]     rsp_tdata;   // pixel_out
   logic                   rsp_tlast;   // frame_end_out
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   contrast_scoreboard sb;
   int req_idle_pct;
   int rsp_idle_pct;
   int hold_off_cycles;
   int held_cycles;
   int beats_counted;
   int cycle_count;

   thermal_frame_contrast_normalizer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // output side: random stalls plus an optional long hold-off
   always @(negedge clock) begin
      if (held_cycles < hold_off_cycles) begin
         rsp_tready = 1'b0;
         held_cycles++;
      end else begin
         rsp_tready = ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
   end

   task automatic push_pixel(input logic op, input logic [PIXEL_W-1:0] px, input logic fe);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = px;
      req_tlast  = fe;
      do @(posedge clock); while (!req_tready);
      if (op == OP_APPLY || sb.norm_en) beats_counted++;
      sb.note_input(op, px, fe);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we    = 1'b0;
      sb.write_reg(idx, val);
   endtask

   // one measure pass, then an apply pass of the same length mostly drawn from its range
   task automatic run_frame();
      int len;
      int roll;
      int lo;
      int hi;
      bit drop_end;
      logic [PIXEL_W-1:0] px;
      roll = $urandom_range(99);
      len  = (roll < 80) ? $urandom_range(8, 1) : (roll < 96) ? $urandom_range(32, 9) : 64;
      roll = $urandom_range(99);
      lo   = $urandom_range(65535);
      if (roll < 15) hi = lo;
      else if (roll < 40) hi = lo + $urandom_range(256);
      else if (roll < 80) hi = lo + $urandom_range(8192);
      else begin
         lo = 0;
         hi = 65535;
      end
      if (hi > 65535) hi = 65535;
      drop_end = ($urandom_range(99) < 4);
      for (int i = 0; i < len; i++)
         push_pixel(OP_MEASURE, PIXEL_W'($urandom_range(hi, lo)),
                    (i == len - 1) && !drop_end);
      for (int i = 0; i < len; i++) begin
         px = ($urandom_range(99) < 25) ? PIXEL_W'($urandom_range(65535))
                                        : PIXEL_W'($urandom_range(hi, lo));
         push_pixel(OP_APPLY, px, i == len - 1);
      end
   endtask

   task automatic run_noise();
      int n;
      n = $urandom_range(6, 1);
      for (int i = 0; i < n; i++)
         push_pixel(1'($urandom_range(1)), PIXEL_W'($urandom_range(65535)),
                    $urandom_range(3) == 0);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] count_val;
      sb              = new();
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = OP_MEASURE;
      req_tlast       = 1'b0;
      csr_we          = 1'b0;
      csr_index       = CSR_ENABLE;
      csr_wdata       = '0;
      req_idle_pct    = 0;
      rsp_idle_pct    = 0;
      hold_off_cycles = 0;
      beats_counted   = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: pass-through before any frame, full-range frame, clamping,
      // flat window, disabled stretch, an out-of-range window length
      push_pixel(OP_APPLY, 16'h1234, 1'b0);
      push_pixel(OP_APPLY, 16'hFFFF, 1'b1);
      push_pixel(OP_MEASURE, 16'h0000, 1'b0);
      push_pixel(OP_MEASURE, 16'hFFFF, 1'b1);
      push_pixel(OP_APPLY, 16'h0000, 1'b0);
      push_pixel(OP_APPLY, 16'hFFFF, 1'b0);
      push_pixel(OP_APPLY, 16'h8000, 1'b0);
      push_pixel(OP_APPLY, 16'h0001, 1'b1);
      push_pixel(OP_MEASURE, 16'h1000, 1'b1);
      push_pixel(OP_APPLY, 16'h0800, 1'b1);
      drain();
      write_csr(CSR_FRAME_COUNT, CSR_DATA_W'(1));
      push_pixel(OP_MEASURE, 16'h2222, 1'b0);
      push_pixel(OP_MEASURE, 16'h2222, 1'b1);
      push_pixel(OP_APPLY, 16'h3333, 1'b0);
      push_pixel(OP_APPLY, 16'h0000, 1'b1);
      push_pixel(OP_MEASURE, 16'h0100, 1'b0);
      push_pixel(OP_MEASURE, 16'h0300, 1'b1);
      push_pixel(OP_APPLY, 16'h0050, 1'b0);
      push_pixel(OP_APPLY, 16'h0200, 1'b0);
      push_pixel(OP_APPLY, 16'hFFFF, 1'b1);
      drain();
      write_csr(CSR_ENABLE, CSR_DATA_W'(0));
      push_pixel(OP_MEASURE, 16'hABCD, 1'b1);
      push_pixel(OP_APPLY, 16'h5555, 1'b1);
      drain();
      write_csr(CSR_ENABLE, CSR_DATA_W'(1));
      write_csr(CSR_FRAME_COUNT, CSR_DATA_W'(0));
      push_pixel(OP_MEASURE, 16'h0010, 1'b0);
      push_pixel(OP_MEASURE, 16'h0020, 1'b1);
      push_pixel(OP_APPLY, 16'h0018, 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         req_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 61 : 0;
         rsp_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 10 : 0;
         for (int seg = 0; seg < 4; seg++) begin
            drain();
            case (seg)
               0: count_val = CSR_DATA_W'(16);
               1: count_val = CSR_DATA_W'(1);
               2: count_val = CSR_DATA_W'(31);
               default: count_val = CSR_DATA_W'($urandom_range(15, 2));
            endcase
            write_csr(CSR_ENABLE, CSR_DATA_W'($urandom_range(99) < 80));
            write_csr(CSR_FRAME_COUNT, count_val);
            if (phase == 2 && seg == 0) begin
               // long output stall while apply beats keep coming
               hold_off_cycles = held_cycles + 300;
               for (int i = 0; i < 60; i++)
                  push_pixel(OP_APPLY, PIXEL_W'($urandom_range(65535)), i == 59);
               drain();
            end
            beats_counted = 0;
            while (beats_counted < SEGMENT_BEATS) begin
               if ($urandom_range(99) < 10) run_noise();
               else run_frame();
            end
         end
      end

      drain();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/tfcn_pkg.sv
hw/rtl/tfcn_gain_div.sv
hw/rtl/thermal_frame_contrast_normalizer.sv
verif/thermal_frame_contrast_normalizer_test.sv
